// File: rtl/sfcd_pkg.sv
package sfcd_pkg;

    // Default limits
    localparam int unsigned     MAX_SOURCE_VERTICES_DEF = 1024;
    localparam longint unsigned MAX_OUTPUT_VERTICES_DEF = 64'd65536;

    // Command queue between front and back (power of two)
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Result kinds on the output channel
    localparam logic [1:0] RES_VERTEX   = 2'd0;
    localparam logic [1:0] RES_TRIANGLE = 2'd1;
    localparam logic [1:0] RES_END      = 2'd2;

    // Classified commands handed from front to back
    typedef enum logic [1:0] {
        CMD_START,
        CMD_END,
        CMD_VERTEX
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        fan;       // start: primitive is a fan
        logic        src_bad;   // vertex: source index out of range
        logic [9:0]  vidx;      // vertex: masked source index
        logic [31:0] u_bits;
        logic [31:0] v_bits;
    } cmd_t;

endpackage

// File: rtl/sfcd_front.sv
module sfcd_front #(
    parameter int unsigned MAX_SOURCE_VERTICES = sfcd_pkg::MAX_SOURCE_VERTICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  logic [31:0]    command_word,
    input  logic           q_full,
    output logic           push,
    output sfcd_pkg::cmd_t push_cmd
);

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_U,
        PH_V,
        PH_INDEX
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [30:0] vleft_reg, vleft_next;
    logic [31:0] held_u_reg, held_v_reg;
    logic        accept;
    logic [31:0] mag;
    logic [30:0] vleft_dec;

    assign cmd_ready = !q_full;
    assign accept    = cmd_valid && cmd_ready;

    // Magnitude of a negative count, saturated to 31 bits
    assign mag       = ~command_word + 32'd1;
    assign vleft_dec = (vleft_reg != 31'd0) ? vleft_reg - 31'd1 : vleft_reg;

    // Word classification and next-state
    always_comb
    begin
        phase_next       = phase_reg;
        vleft_next       = vleft_reg;
        push             = 1'b0;
        push_cmd.kind    = sfcd_pkg::CMD_VERTEX;
        push_cmd.fan     = command_word[31];
        push_cmd.src_bad = (command_word >= 32'(MAX_SOURCE_VERTICES));
        push_cmd.vidx    = command_word[9:0];
        push_cmd.u_bits  = held_u_reg;
        push_cmd.v_bits  = held_v_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    push = 1'b1;
                    if (command_word == 32'd0)
                    begin
                        push_cmd.kind = sfcd_pkg::CMD_END;
                        vleft_next    = 31'd0;
                    end
                    else
                    begin
                        push_cmd.kind = sfcd_pkg::CMD_START;
                        phase_next    = PH_U;
                        if (command_word[31])
                            vleft_next = mag[31] ? 31'h7FFF_FFFF : mag[30:0];
                        else
                            vleft_next = command_word[30:0];
                    end
                end
                PH_U:
                    phase_next = PH_V;
                PH_V:
                    phase_next = PH_INDEX;
                PH_INDEX:
                begin
                    push       = 1'b1;
                    vleft_next = vleft_dec;
                    phase_next = (vleft_dec == 31'd0) ? PH_COUNT : PH_U;
                end
                default:
                    phase_next = PH_COUNT;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            vleft_reg <= 31'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            vleft_reg <= vleft_next;
        end
    end

    // Held texture words
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_U)
            held_u_reg <= command_word;
        if (accept && phase_reg == PH_V)
            held_v_reg <= command_word;
    end

endmodule

// File: rtl/sfcd_queue.sv
module sfcd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfcd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output sfcd_pkg::cmd_t head_cmd
);

    localparam int unsigned AW = sfcd_pkg::QUEUE_AW;

    sfcd_pkg::cmd_t mem_reg [sfcd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           do_push, do_pop;

    assign full     = (count_reg == (AW+1)'(sfcd_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: rtl/sfcd_back.sv
module sfcd_back #(
    parameter longint unsigned MAX_OUTPUT_VERTICES = sfcd_pkg::MAX_OUTPUT_VERTICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  sfcd_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [1:0]     result_kind,
    output logic [31:0]    tex_u_bits,
    output logic [31:0]    tex_v_bits,
    output logic [9:0]     vertex_index,
    output logic [15:0]    corner_a,
    output logic [15:0]    corner_b,
    output logic [15:0]    corner_c,
    output logic           index_error
);

    localparam logic [16:0] OUT_LIMIT =
        (MAX_OUTPUT_VERTICES < 64'd65536) ? 17'(MAX_OUTPUT_VERTICES) : 17'h10000;

    logic [15:0] pvc_reg, pvc_next;
    logic [15:0] base_reg, base_next;
    logic        parity_reg, parity_next;
    logic        fan_reg, fan_next;
    logic        ovf_reg, ovf_next;
    logic        out_valid_reg;

    logic        slot_free, produce;
    logic [16:0] base_sum, abs_new;
    logic [15:0] n, nm1, nm2, nm3;
    logic        ovf_vtx;
    logic [1:0]  kind_next;
    logic [15:0] ca_next, cb_next, cc_next;
    logic        err_next;

    assign slot_free = !out_valid_reg || res_ready;
    assign pop       = q_valid && (head_cmd.kind == sfcd_pkg::CMD_START || slot_free);
    assign produce   = pop && (head_cmd.kind != sfcd_pkg::CMD_START);
    assign res_valid = out_valid_reg;

    // Vertex count and absolute index of the new vertex
    assign ovf_vtx  = ovf_reg || (pvc_reg == 16'hFFFF);
    assign n        = (pvc_reg == 16'hFFFF) ? pvc_reg : pvc_reg + 16'd1;
    assign nm1      = n - 16'd1;
    assign nm2      = n - 16'd2;
    assign nm3      = n - 16'd3;
    assign abs_new  = {1'b0, base_reg} + {1'b0, nm1};
    assign base_sum = {1'b0, base_reg} + {1'b0, pvc_reg};

    // Command execution
    always_comb
    begin
        pvc_next    = pvc_reg;
        base_next   = base_reg;
        parity_next = parity_reg;
        fan_next    = fan_reg;
        ovf_next    = ovf_reg;
        kind_next   = sfcd_pkg::RES_END;
        ca_next     = 16'd0;
        cb_next     = 16'd0;
        cc_next     = 16'd0;
        err_next    = 1'b0;
        if (pop)
        begin
            case (head_cmd.kind)
                sfcd_pkg::CMD_START:
                begin
                    fan_next    = head_cmd.fan;
                    parity_next = 1'b0;
                    pvc_next    = 16'd0;
                    if (base_sum[16])
                    begin
                        base_next = 16'hFFFF;
                        ovf_next  = 1'b1;
                    end
                    else
                        base_next = base_sum[15:0];
                end
                sfcd_pkg::CMD_END:
                begin
                    base_next = 16'd0;
                    pvc_next  = 16'd0;
                    ovf_next  = 1'b0;
                end
                sfcd_pkg::CMD_VERTEX:
                begin
                    pvc_next  = n;
                    ovf_next  = ovf_vtx;
                    err_next  = ovf_vtx || head_cmd.src_bad || (abs_new >= OUT_LIMIT);
                    kind_next = sfcd_pkg::RES_VERTEX;
                    if (n >= 16'd3)
                    begin
                        kind_next = sfcd_pkg::RES_TRIANGLE;
                        if (fan_reg)
                        begin
                            ca_next = base_reg;
                            cb_next = base_reg + nm1;
                            cc_next = base_reg + nm2;
                        end
                        else
                        begin
                            parity_next = !parity_reg;
                            if (!parity_reg)
                            begin
                                ca_next = base_reg + nm1;
                                cb_next = base_reg + nm2;
                                cc_next = base_reg + nm3;
                            end
                            else
                            begin
                                ca_next = base_reg + nm3;
                                cb_next = base_reg + nm2;
                                cc_next = base_reg + nm1;
                            end
                        end
                    end
                end
                default:
                    kind_next = sfcd_pkg::RES_END;
            endcase
        end
    end

    // Primitive state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvc_reg       <= 16'd0;
            base_reg      <= 16'd0;
            parity_reg    <= 1'b0;
            fan_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pvc_reg    <= pvc_next;
            base_reg   <= base_next;
            parity_reg <= parity_next;
            fan_reg    <= fan_next;
            ovf_reg    <= ovf_next;
            if (produce)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            result_kind <= kind_next;
            corner_a    <= ca_next;
            corner_b    <= cb_next;
            corner_c    <= cc_next;
            index_error <= err_next;
            if (head_cmd.kind == sfcd_pkg::CMD_VERTEX)
            begin
                tex_u_bits   <= head_cmd.u_bits;
                tex_v_bits   <= head_cmd.v_bits;
                vertex_index <= head_cmd.vidx;
            end
            else
            begin
                tex_u_bits   <= 32'd0;
                tex_v_bits   <= 32'd0;
                vertex_index <= 10'd0;
            end
        end
    end

endmodule

// File: rtl/strip_fan_command_decoder_top.sv
// Result path: an index or zero-count word is classified by the front into the command queue,
//   then executed by the back into the output register, which presents its result.
// Throughput: 1 command word per cycle, sustained while the result side takes one per cycle;
//   the 4-entry command queue and the output register absorb short stalls.
// Reset (rst_n, async, active low) returns the parser to expecting a count word, with
//   base, vertex count, parity and overflow cleared and the queue and output empty.
module strip_fan_command_decoder_top #(
    parameter int unsigned     MAX_SOURCE_VERTICES = sfcd_pkg::MAX_SOURCE_VERTICES_DEF,
    parameter longint unsigned MAX_OUTPUT_VERTICES = sfcd_pkg::MAX_OUTPUT_VERTICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [31:0] command_word,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  result_kind,
    output logic [31:0] tex_u_bits,
    output logic [31:0] tex_v_bits,
    output logic [9:0]  vertex_index,
    output logic [15:0] corner_a,
    output logic [15:0] corner_b,
    output logic [15:0] corner_c,
    output logic        index_error
);

    logic           push, q_full, q_valid, pop;
    sfcd_pkg::cmd_t push_cmd, head_cmd;

    // Word parser
    sfcd_front #(
        .MAX_SOURCE_VERTICES(MAX_SOURCE_VERTICES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command_word(command_word),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue
    sfcd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .head_cmd(head_cmd)
    );

    // Triangle assembler
    sfcd_back #(
        .MAX_OUTPUT_VERTICES(MAX_OUTPUT_VERTICES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .result_kind (result_kind),
        .tex_u_bits  (tex_u_bits),
        .tex_v_bits  (tex_v_bits),
        .vertex_index(vertex_index),
        .corner_a    (corner_a),
        .corner_b    (corner_b),
        .corner_c    (corner_c),
        .index_error (index_error)
    );

endmodule
